>>> design/vta_pkg.sv
// ----------------------------------------------------------------------------
// vta_pkg
// Shared types and constants for the vertex tangent accumulator.
// ----------------------------------------------------------------------------
package vta_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int VIDX_W       = 10;

	localparam logic [1:0] REQ_LOAD     = 2'd0;
	localparam logic [1:0] REQ_TRIANGLE = 2'd1;
	localparam logic [1:0] REQ_READ     = 2'd2;
	localparam logic [1:0] REQ_UNKNOWN  = 2'd3;

	localparam logic [9:0]         COUNT_MAX = 10'd1023;
	localparam logic signed [24:0] SUM_MAX   = 25'sd8388607;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [9:0]        vertex_index;
		logic [9:0]        corner_a;
		logic [9:0]        corner_b;
		logic [9:0]        corner_c;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} req_t;

	typedef struct packed {
		logic [9:0]         out_index;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic               unused_vertex;
	} rsp_t;

	// one stored vertex
	typedef struct packed {
		logic signed [15:0] tex_v;
		logic signed [15:0] tex_u;
		logic signed [15:0] pos_z;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_x;
	} vtx_t;

	// one accumulator entry
	typedef struct packed {
		logic [9:0]         cnt;
		logic signed [23:0] sz;
		logic signed [23:0] sy;
		logic signed [23:0] sx;
	} acc_t;

	// handshake of the iterative units
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

>>> design/vta_isqrt.sv
// ----------------------------------------------------------------------------
// vta_isqrt
// Floor square root of a 62-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vta_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [61:0]        x,
	output vta_pkg::unit_sts_t sts,
	output logic [30:0]        root
);

	logic [61:0] x_q;
	logic [61:0] r_q;
	logic [61:0] b_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [61:0] rb;

	assign rb = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			r_q <= '0;
			b_q <= 62'(1) << 60;
		end else if (busy_q) begin
			if (x_q >= rb) begin
				x_q <= x_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = r_q[30:0];

endmodule

>>> design/vta_div.sv
// ----------------------------------------------------------------------------
// vta_div
// Restoring divider, 24 quotient bits, one bit per cycle.
// Needs num < den * 2^24.
// ----------------------------------------------------------------------------
module vta_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [47:0]        num,
	input  logic [30:0]        den,
	output vta_pkg::unit_sts_t sts,
	output logic [23:0]        quo
);

	logic [30:0] rem_q;
	logic [30:0] den_q;
	logic [23:0] nsh_q;
	logic [23:0] q_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;
	logic        ge;

	assign trial = {rem_q, nsh_q[23]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd23;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {7'd0, num[47:24]};
			nsh_q <= num[23:0];
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= 31'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[30:0];
			end
			nsh_q <= nsh_q << 1;
			q_q   <= {q_q[22:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = q_q;

endmodule

>>> design/vertex_tangent_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_tangent_accumulator
// Per-vertex tangent generation: vertex store, per-corner unit tangent,
// read-modify-write accumulation and averaged read-back.
// ----------------------------------------------------------------------------
//
//  channel | signals                    | dir | beat
//  --------+----------------------------+-----+--------------------------------
//  req     | req_valid, req_stall, req  | in  | load, triangle or read request
//  rsp     | rsp_valid, rsp_stall, rsp  | out | averaged tangent (reads only)
//
//  Load: vertex and accumulator memories written at once.
//  Triangle: vertex fetch, then per corner products, shift, squares, square
//  root (start, 31 steps, done), division by the length for each component
//  (start, 24 steps, done; skipped when the length is zero) and a closing
//  step, then a read-modify-write of the accumulator for each corner.
//  Read: three passes on the shared divider, skipped when the count is zero.
//  Reset clears control only; memory contents are undefined until loaded.
//  One request in flight; req_stall is high while it runs, also while a
//  finished read waits for a stalled rsp to free the output register.
//
module vertex_tangent_accumulator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  vta_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output vta_pkg::rsp_t   rsp
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_VRD    = 5'd1;
	localparam logic [4:0] S_MUL    = 5'd2;
	localparam logic [4:0] S_SUB    = 5'd3;
	localparam logic [4:0] S_SHIFT  = 5'd4;
	localparam logic [4:0] S_SQ     = 5'd5;
	localparam logic [4:0] S_SQL    = 5'd6;
	localparam logic [4:0] S_SQRT   = 5'd7;
	localparam logic [4:0] S_SQRTW  = 5'd8;
	localparam logic [4:0] S_DIV    = 5'd9;
	localparam logic [4:0] S_DIVW   = 5'd10;
	localparam logic [4:0] S_CDONE  = 5'd11;
	localparam logic [4:0] S_ACCRD  = 5'd12;
	localparam logic [4:0] S_ACCWR  = 5'd13;
	localparam logic [4:0] S_RDRD   = 5'd14;
	localparam logic [4:0] S_RDDAT  = 5'd15;
	localparam logic [4:0] S_RDDIV  = 5'd16;
	localparam logic [4:0] S_RDDIVW = 5'd17;
	localparam logic [4:0] S_FINISH = 5'd18;

	logic [4:0] state_q;
	logic [1:0] j_q;     // component / fetch counter
	logic [1:0] ci_q;    // corner counter

	// memories
	vta_pkg::vtx_t vmem [vta_pkg::MAX_VERTICES];
	vta_pkg::acc_t amem [vta_pkg::MAX_VERTICES];
	vta_pkg::vtx_t vrd_q;
	vta_pkg::acc_t ard_q;
	logic [9:0]    vrd_addr;
	logic [9:0]    ard_addr;
	logic          vmem_we;
	logic          amem_we;
	logic [9:0]    amem_waddr;
	vta_pkg::acc_t amem_wdata;
	vta_pkg::vtx_t vmem_wdata;

	// request context
	logic [9:0] idx0_q, idx1_q, idx2_q;   // corners, rotated as they are used
	logic [9:0] rdidx_q;
	vta_pkg::vtx_t v0_q, v1_q, v2_q;      // p, q, r of the current corner

	// corner datapath
	logic signed [33:0] p1_q, p2_q;
	logic [33:0]        m_q   [3];
	logic               neg_q [3];
	logic [29:0]        ms_q  [3];
	logic [59:0]        sq_q;
	logic [61:0]        l2_q;
	logic [30:0]        len_q;
	logic signed [15:0] tcur_q [3];
	logic signed [15:0] tan_q  [3][3];    // [corner][component], A first
	vta_pkg::acc_t      racc_q;
	logic signed [15:0] avg_q  [3];

	// output register
	logic          rsp_valid_q;
	vta_pkg::rsp_t rsp_q;

	// shared units
	logic               sqrt_start;
	vta_pkg::unit_sts_t sqrt_sts;
	logic [30:0]        sqrt_root;
	logic               div_start;
	logic [47:0]        div_num;
	logic [30:0]        div_den;
	vta_pkg::unit_sts_t div_sts;
	logic [23:0]        div_quo;

	logic req_acc;
	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	// ---------------- component select for the product stage ----------------
	logic signed [15:0] pp, pq, pr;
	logic signed [16:0] e12, e13, dq, dr;
	logic signed [34:0] nval;
	logic [33:0]        m_or;
	logic [2:0]         shamt;

	always_comb begin
		unique case (j_q)
			2'd0: begin
				pp = v0_q.pos_x; pq = v1_q.pos_x; pr = v2_q.pos_x;
			end
			2'd1: begin
				pp = v0_q.pos_y; pq = v1_q.pos_y; pr = v2_q.pos_y;
			end
			default: begin
				pp = v0_q.pos_z; pq = v1_q.pos_z; pr = v2_q.pos_z;
			end
		endcase
	end

	assign e12  = {pq[15], pq} - {pp[15], pp};
	assign e13  = {pr[15], pr} - {pp[15], pp};
	assign dq   = {v1_q.tex_v[15], v1_q.tex_v} - {v0_q.tex_v[15], v0_q.tex_v};
	assign dr   = {v2_q.tex_v[15], v2_q.tex_v} - {v0_q.tex_v[15], v0_q.tex_v};
	assign nval = {p1_q[33], p1_q} - {p2_q[33], p2_q};

	// smallest shift that brings every magnitude below 2^30
	assign m_or = m_q[0] | m_q[1] | m_q[2];
	always_comb begin
		priority if (m_or[33]) shamt = 3'd4;
		else if (m_or[32])     shamt = 3'd3;
		else if (m_or[31])     shamt = 3'd2;
		else if (m_or[30])     shamt = 3'd1;
		else                   shamt = 3'd0;
	end

	// ---------------- accumulate: saturating add ----------------
	function automatic logic signed [23:0] sat_add(logic signed [23:0] s,
		logic signed [15:0] t);
		logic signed [24:0] w;
		w = {s[23], s} + {{9{t[15]}}, t};
		if (w > vta_pkg::SUM_MAX) begin
			return 24'(vta_pkg::SUM_MAX);
		end else if (w < -vta_pkg::SUM_MAX) begin
			return 24'(-vta_pkg::SUM_MAX);
		end
		return w[23:0];
	endfunction

	logic signed [23:0] rsum;
	logic [23:0]        rmag;

	always_comb begin
		unique case (j_q)
			2'd0:    rsum = racc_q.sx;
			2'd1:    rsum = racc_q.sy;
			default: rsum = racc_q.sz;
		endcase
		rmag = rsum[23] ? 24'(-rsum) : rsum;
	end

	// ---------------- memory ports ----------------
	always_comb begin
		unique case (j_q)
			2'd0:    vrd_addr = idx0_q;
			2'd1:    vrd_addr = idx1_q;
			default: vrd_addr = idx2_q;
		endcase
	end

	assign ard_addr = (state_q == S_RDRD) ? rdidx_q : idx0_q;

	assign vmem_we          = req_acc && (req.req_type == vta_pkg::REQ_LOAD);
	assign vmem_wdata.pos_x = req.pos_x;
	assign vmem_wdata.pos_y = req.pos_y;
	assign vmem_wdata.pos_z = req.pos_z;
	assign vmem_wdata.tex_u = req.tex_u;
	assign vmem_wdata.tex_v = req.tex_v;

	always_comb begin
		amem_we    = 1'b0;
		amem_waddr = idx0_q;
		amem_wdata = ard_q;
		if (vmem_we) begin
			amem_we    = 1'b1;
			amem_waddr = req.vertex_index;
			amem_wdata = '0;
		end else if (state_q == S_ACCWR && ard_q.cnt < vta_pkg::COUNT_MAX) begin
			amem_we       = 1'b1;
			amem_wdata.cnt = ard_q.cnt + 10'd1;
			amem_wdata.sx  = sat_add(ard_q.sx, tan_q[0][0]);
			amem_wdata.sy  = sat_add(ard_q.sy, tan_q[0][1]);
			amem_wdata.sz  = sat_add(ard_q.sz, tan_q[0][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (vmem_we) begin
			vmem[req.vertex_index] <= vmem_wdata;
		end
		vrd_q <= vmem[vrd_addr];
	end

	always_ff @(posedge clk) begin
		if (amem_we) begin
			amem[amem_waddr] <= amem_wdata;
		end
		ard_q <= amem[ard_addr];
	end

	// ---------------- shared units ----------------
	assign sqrt_start = (state_q == S_SQRT);
	assign div_start  = (state_q == S_DIV) || (state_q == S_RDDIV);

	always_comb begin
		if (state_q == S_RDDIV) begin
			div_num = 48'(rmag) + 48'(racc_q.cnt >> 1);
			div_den = 31'(racc_q.cnt);
		end else begin
			div_num = 48'({ms_q[j_q], 14'd0}) + 48'(len_q >> 1);
			div_den = len_q;
		end
	end

	vta_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (l2_q),
		.sts    (sqrt_sts),
		.root   (sqrt_root)
	);

	vta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			ci_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (state_q == S_FINISH && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					j_q  <= '0;
					ci_q <= '0;
					if (req_acc && req.req_type == vta_pkg::REQ_TRIANGLE) begin
						state_q <= S_VRD;
					end else if (req_acc && req.req_type == vta_pkg::REQ_READ) begin
						state_q <= S_RDRD;
					end
				end
				S_VRD: begin
					if (j_q == 2'd3) begin
						j_q     <= '0;
						state_q <= S_MUL;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_MUL: state_q <= S_SUB;
				S_SUB: begin
					if (j_q == 2'd2) begin
						j_q     <= '0;
						state_q <= S_SHIFT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_SHIFT: state_q <= S_SQ;
				S_SQ: begin
					if (j_q == 2'd2) begin
						j_q     <= '0;
						state_q <= S_SQL;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_SQL: state_q <= S_SQRT;
				S_SQRT: state_q <= S_SQRTW;
				S_SQRTW: begin
					if (sqrt_sts.done) begin
						state_q <= (sqrt_root == '0) ? S_CDONE : S_DIV;
					end
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_sts.done) begin
						if (j_q == 2'd2) begin
							j_q     <= '0;
							state_q <= S_CDONE;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_CDONE: begin
					j_q <= '0;
					if (ci_q == 2'd2) begin
						ci_q    <= '0;
						state_q <= S_ACCRD;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_ACCRD: state_q <= S_ACCWR;
				S_ACCWR: begin
					if (ci_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_ACCRD;
					end
				end
				S_RDRD: state_q <= S_RDDAT;
				S_RDDAT: begin
					j_q     <= '0;
					state_q <= (ard_q.cnt == '0) ? S_FINISH : S_RDDIV;
				end
				S_RDDIV: state_q <= S_RDDIVW;
				S_RDDIVW: begin
					if (div_sts.done) begin
						if (j_q == 2'd2) begin
							state_q <= S_FINISH;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= S_RDDIV;
						end
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (req_acc) begin
			idx0_q  <= req.corner_a;
			idx1_q  <= req.corner_b;
			idx2_q  <= req.corner_c;
			rdidx_q <= req.vertex_index;
		end

		// fetched vertices shift in: A lands in v0 after the third capture
		if (state_q == S_VRD && j_q != 2'd0) begin
			v2_q <= vrd_q;
			v1_q <= v2_q;
			v0_q <= v1_q;
		end

		if (state_q == S_MUL) begin
			p1_q <= e13 * dq;
			p2_q <= e12 * dr;
		end

		if (state_q == S_SUB) begin
			neg_q[j_q] <= nval[34];
			m_q[j_q]   <= nval[34] ? 34'(-nval) : nval[33:0];
		end

		if (state_q == S_SHIFT) begin
			for (int i = 0; i < 3; i++) begin
				ms_q[i] <= 30'(m_q[i] >> shamt);
			end
		end

		if (state_q == S_SQ) begin
			sq_q <= 60'(ms_q[j_q]) * 60'(ms_q[j_q]);
			if (j_q == 2'd0) begin
				l2_q <= '0;
			end else begin
				l2_q <= l2_q + 62'(sq_q);
			end
		end
		if (state_q == S_SQL) begin
			l2_q <= l2_q + 62'(sq_q);
		end

		if (state_q == S_SQRTW && sqrt_sts.done) begin
			len_q <= sqrt_root;
			for (int i = 0; i < 3; i++) begin
				tcur_q[i] <= '0;
			end
		end

		if (state_q == S_DIVW && div_sts.done) begin
			tcur_q[j_q] <= neg_q[j_q] ? -16'(div_quo[14:0]) : 16'(div_quo[14:0]);
		end

		// corner finished: tangent joins the list, triangle rotates to next corner
		if (state_q == S_CDONE) begin
			for (int i = 0; i < 3; i++) begin
				tan_q[2][i] <= tcur_q[i];
				tan_q[1][i] <= tan_q[2][i];
				tan_q[0][i] <= tan_q[1][i];
			end
			v0_q <= v1_q;
			v1_q <= v2_q;
			v2_q <= v0_q;
		end

		// accumulation done for one corner: move to the next
		if (state_q == S_ACCWR) begin
			idx0_q <= idx1_q;
			idx1_q <= idx2_q;
			idx2_q <= idx0_q;
			for (int i = 0; i < 3; i++) begin
				tan_q[0][i] <= tan_q[1][i];
				tan_q[1][i] <= tan_q[2][i];
			end
		end

		if (state_q == S_RDDAT) begin
			racc_q <= ard_q;
			for (int i = 0; i < 3; i++) begin
				avg_q[i] <= '0;
			end
		end

		if (state_q == S_RDDIVW && div_sts.done) begin
			avg_q[j_q] <= rsum[23] ? -div_quo[15:0] : div_quo[15:0];
		end

		if (state_q == S_FINISH && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.out_index     <= rdidx_q;
			rsp_q.tangent_x     <= avg_q[0];
			rsp_q.tangent_y     <= avg_q[1];
			rsp_q.tangent_z     <= avg_q[2];
			rsp_q.unused_vertex <= (racc_q.cnt == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside finish");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_sqrt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_sts.busy)
		else $error("root unit started while busy");

	a_acc_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACCWR) |-> $past(state_q == S_ACCRD))
		else $error("accumulator write without preceding read");

endmodule
